@@ rtl/crc8_frame_receiver_unit_macros.svh @@
// Assertion macros shared by the receiver checker.
// Depends on nothing; included by files that assert.
`ifndef CRC8_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CRC8_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CRC8FR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8 frame receiver: check failed");

// next-cycle implication, disabled while reset is low
`define CRC8FR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8 frame receiver: check failed");

`endif

@@ rtl/crc8fr_pkg.sv @@
// Types, byte constants and the CRC-8 step for the frame receiver.
// Depends on nothing; used by the top level and the checker.
`default_nettype none

package crc8fr_pkg;

    typedef enum logic [2:0] {
        ST_HEAD1 = 3'd0,
        ST_HEAD2 = 3'd1,
        ST_LEN   = 3'd2,
        ST_CMD   = 3'd3,
        ST_DATA  = 3'd4,
        ST_CRC   = 3'd5,
        ST_TAIL1 = 3'd6,
        ST_TAIL2 = 3'd7
    } parse_state_t;

    typedef enum logic [2:0] {
        FS_GOOD      = 3'd0,
        FS_LEN_LONG  = 3'd1,
        FS_CRC_BAD   = 3'd2,
        FS_TAIL1_BAD = 3'd3,
        FS_TAIL2_BAD = 3'd4
    } frame_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } out_kind_t;

    localparam logic [7:0] HDR_BYTE0     = 8'hAA;
    localparam logic [7:0] HDR_BYTE1     = 8'h55;
    localparam logic [7:0] TAIL_BYTE0    = 8'h0D;
    localparam logic [7:0] TAIL_BYTE1    = 8'h0A;
    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] MAX_LEN_RESET = 8'd60;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/crc8_frame_receiver_unit.sv @@
// Top level of the CRC-8 frame receiver: parser state machine and result register.
// Depends on crc8fr_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/rx_byte carries one received byte per request.
//   Frames are AA 55, length, command, payload, CRC-8 (poly 0x07, init 0), 0D 0A.
//   Output channel out_valid/out_ready carries one result: a payload byte
//   (out_kind 0) with its index, or a frame-end report (out_kind 1) with status.
//   cfg_wr_en/cfg_wr_data write max_payload_len at once; write only while idle.
//   A result shows on out_valid in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless a stalled result holds in_ready low;
//   the parser updates in the accepting cycle and a single result register sits between the two sides.
//   in_ready is high while the result register is empty or being taken, so a
//   stalled receiver holds its result and stops input in the same cycle.
//   Reset: parser hunts for AA, result register empty, max_payload_len is 60.
`default_nettype none

module crc8_frame_receiver_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            out_kind,
    output logic [7:0]      payload_byte,
    output logic [7:0]      byte_index,
    output logic [7:0]      out_cmd,
    output logic [7:0]      out_len,
    output logic [2:0]      frame_status,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);
    import crc8fr_pkg::*;

    parse_state_t  state_reg, state_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    count_reg, count_next;
    logic [7:0]    max_len_reg;
    logic          out_valid_reg, out_valid_next;
    logic          res_load;
    out_kind_t     res_kind;
    logic [7:0]    res_byte;
    logic [7:0]    res_index;
    logic [7:0]    res_cmd;
    frame_status_t res_status;
    logic          kind_reg;
    logic [7:0]    byte_reg, index_reg, cmd_out_reg, len_out_reg;
    logic [2:0]    status_reg;
    logic          accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        res_load   = 1'b0;
        res_kind   = KIND_REPORT;
        res_byte   = 8'd0;
        res_index  = 8'd0;
        res_cmd    = cmd_reg;
        res_status = FS_GOOD;
        if (accept)
        begin
            case (state_reg)
                ST_HEAD2:
                begin
                    state_next = (rx_byte == HDR_BYTE1) ? ST_LEN : ST_HEAD1;
                end
                ST_LEN:
                begin
                    len_next = rx_byte;
                    crc_next = crc8_step(8'd0, rx_byte);
                    if (rx_byte > max_len_reg)
                    begin
                        res_load   = 1'b1;
                        res_cmd    = 8'd0;
                        res_status = FS_LEN_LONG;
                        state_next = ST_HEAD1;
                    end
                    else
                    begin
                        state_next = ST_CMD;
                    end
                end
                ST_CMD:
                begin
                    cmd_next   = rx_byte;
                    crc_next   = crc8_step(crc_reg, rx_byte);
                    state_next = (len_reg != 8'd0) ? ST_DATA : ST_CRC;
                end
                ST_DATA:
                begin
                    crc_next   = crc8_step(crc_reg, rx_byte);
                    res_load   = 1'b1;
                    res_kind   = KIND_PAYLOAD;
                    res_byte   = rx_byte;
                    res_index  = count_reg;
                    count_next = count_reg + 8'd1;
                    if (count_next >= len_reg)
                        state_next = ST_CRC;
                end
                ST_CRC:
                begin
                    if (rx_byte != crc_reg)
                    begin
                        res_load   = 1'b1;
                        res_status = FS_CRC_BAD;
                        state_next = ST_HEAD1;
                    end
                    else
                    begin
                        state_next = ST_TAIL1;
                    end
                end
                ST_TAIL1:
                begin
                    if (rx_byte != TAIL_BYTE0)
                    begin
                        res_load   = 1'b1;
                        res_status = FS_TAIL1_BAD;
                        state_next = ST_HEAD1;
                    end
                    else
                    begin
                        state_next = ST_TAIL2;
                    end
                end
                ST_TAIL2:
                begin
                    count_next = 8'd0;
                    res_load   = 1'b1;
                    res_status = (rx_byte == TAIL_BYTE1) ? FS_GOOD : FS_TAIL2_BAD;
                    state_next = ST_HEAD1;
                end
                default:
                begin
                    crc_next   = 8'd0;
                    state_next = ST_HEAD1;
                    if (rx_byte == HDR_BYTE0)
                    begin
                        count_next = 8'd0;
                        state_next = ST_HEAD2;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD1;
            len_reg       <= 8'd0;
            cmd_reg       <= 8'd0;
            crc_reg       <= 8'd0;
            count_reg     <= 8'd0;
            max_len_reg   <= MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cmd_reg       <= cmd_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
        end
    end

    // load result payload on a new result, hold otherwise
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            kind_reg    <= res_kind;
            byte_reg    <= res_byte;
            index_reg   <= res_index;
            cmd_out_reg <= res_cmd;
            len_out_reg <= len_next;
            status_reg  <= res_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign payload_byte = byte_reg;
    assign byte_index   = index_reg;
    assign out_cmd      = cmd_out_reg;
    assign out_len      = len_out_reg;
    assign frame_status = status_reg;

endmodule

`default_nettype wire

@@ rtl/crc8fr_checker.sv @@
// Port-level checker for the CRC-8 frame receiver, bound to the top level.
// Depends on crc8fr_pkg and crc8_frame_receiver_unit_macros.svh.
`default_nettype none

`include "crc8_frame_receiver_unit_macros.svh"

module crc8fr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_kind,
    input wire logic [7:0] payload_byte,
    input wire logic [7:0] byte_index,
    input wire logic [7:0] out_cmd,
    input wire logic [7:0] out_len,
    input wire logic [2:0] frame_status
);
    import crc8fr_pkg::*;

    logic [35:0] out_bits;

    assign out_bits = {out_kind, payload_byte, byte_index, out_cmd, out_len, frame_status};

    // hold a stalled result
    `CRC8FR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bits))
    `CRC8FR_ASSERT_NOW(a_payload_fields, clk, rst_n, out_valid && out_kind == KIND_PAYLOAD, frame_status == FS_GOOD && byte_index < out_len)
    `CRC8FR_ASSERT_NOW(a_report_fields, clk, rst_n, out_valid && out_kind == KIND_REPORT, payload_byte == 8'd0 && byte_index == 8'd0)
    `CRC8FR_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, frame_status <= FS_TAIL2_BAD)

endmodule

bind crc8_frame_receiver_unit crc8fr_checker u_crc8fr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .out_cmd      (out_cmd),
    .out_len      (out_len),
    .frame_status (frame_status)
);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for crc8_frame_receiver_unit: framed byte streams in,
// payload and report results out.
// Depends on crc8fr_pkg for state, status and kind codes and the frame byte constants.
`default_nettype none

module tb;
    import crc8fr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [2:0] status;
    } rx_result_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_TAIL1,
        FAULT_TAIL2
    } frame_fault_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b1;
    logic       out_kind;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] out_cmd;
    logic [7:0] out_len;
    logic [2:0] frame_status;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;

    rx_result_t   pending_results[$];
    rx_result_t   oldest;
    parse_state_t parse_q = ST_HEAD1;
    logic [7:0]   len_q = 8'h00;
    logic [7:0]   cmd_q = 8'h00;
    logic [7:0]   crc_q = 8'h00;
    logic [7:0]   count_q = 8'h00;
    logic [7:0]   max_len = MAX_LEN_RESET;
    logic         idle_on = 1'b1;
    int           errors = 0;
    int           bytes_sent = 0;
    int           quiet_cycles = 0;

    crc8_frame_receiver_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .out_cmd      (out_cmd),
        .out_len      (out_len),
        .frame_status (frame_status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        repeat (8)
        begin
            if (r[7])
                r = (r << 1) ^ CRC_POLY;
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic rx_result_t frame_report(input logic [7:0] cmd, input logic [2:0] status);
        rx_result_t r;
        r.kind   = KIND_REPORT;
        r.data   = 8'h00;
        r.index  = 8'h00;
        r.cmd    = cmd;
        r.len    = len_q;
        r.status = status;
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        rx_result_t r;
        logic       hit;
        hit = 1'b0;
        case (parse_q)
            ST_HEAD2:
            begin
                if (b == HDR_BYTE1)
                    parse_q = ST_LEN;
                else
                    parse_q = ST_HEAD1;
            end
            ST_LEN:
            begin
                len_q = b;
                crc_q = crc_update(8'h00, b);
                if (b > max_len)
                begin
                    r = frame_report(8'h00, FS_LEN_LONG);
                    hit = 1'b1;
                    parse_q = ST_HEAD1;
                end
                else
                    parse_q = ST_CMD;
            end
            ST_CMD:
            begin
                cmd_q = b;
                crc_q = crc_update(crc_q, b);
                if (len_q > 8'h00)
                    parse_q = ST_DATA;
                else
                    parse_q = ST_CRC;
            end
            ST_DATA:
            begin
                crc_q = crc_update(crc_q, b);
                r.kind   = KIND_PAYLOAD;
                r.data   = b;
                r.index  = count_q;
                r.cmd    = cmd_q;
                r.len    = len_q;
                r.status = FS_GOOD;
                hit = 1'b1;
                count_q = count_q + 8'd1;
                if (count_q >= len_q)
                    parse_q = ST_CRC;
            end
            ST_CRC:
            begin
                if (b != crc_q)
                begin
                    r = frame_report(cmd_q, FS_CRC_BAD);
                    hit = 1'b1;
                    parse_q = ST_HEAD1;
                end
                else
                    parse_q = ST_TAIL1;
            end
            ST_TAIL1:
            begin
                if (b != TAIL_BYTE0)
                begin
                    r = frame_report(cmd_q, FS_TAIL1_BAD);
                    hit = 1'b1;
                    parse_q = ST_HEAD1;
                end
                else
                    parse_q = ST_TAIL2;
            end
            ST_TAIL2:
            begin
                count_q = 8'h00;
                if (b == TAIL_BYTE1)
                    r = frame_report(cmd_q, FS_GOOD);
                else
                    r = frame_report(cmd_q, FS_TAIL2_BAD);
                hit = 1'b1;
                parse_q = ST_HEAD1;
            end
            default:
            begin
                parse_q = ST_HEAD1;
                crc_q = 8'h00;
                if (b == HDR_BYTE0)
                begin
                    count_q = 8'h00;
                    parse_q = ST_HEAD2;
                end
            end
        endcase
        if (hit)
            pending_results.insert(pending_results.size(), r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                              input frame_fault_t fault);
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] flip;
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(len);
        if (len <= max_len)
        begin
            c = crc_update(8'h00, len);
            send_byte(cmd);
            c = crc_update(c, cmd);
            for (int i = 0; i < len; i++)
            begin
                d = 8'($urandom);
                send_byte(d);
                c = crc_update(c, d);
            end
            flip = 8'($urandom_range(1, 255));
            send_byte((fault == FAULT_CRC) ? c ^ flip : c);
            send_byte((fault == FAULT_TAIL1) ? TAIL_BYTE0 ^ flip : TAIL_BYTE0);
            send_byte((fault == FAULT_TAIL2) ? TAIL_BYTE1 ^ flip : TAIL_BYTE1);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [7:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        max_len = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(HDR_BYTE0);
        send_byte(8'h00);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
    endtask

    task automatic test_zero_length();
        send_frame(8'h00, 8'h00, FAULT_NONE);
    endtask

    task automatic test_length_limit();
        send_frame(8'hFF, 8'hFF, FAULT_NONE);
    endtask

    task automatic test_bad_tail();
        send_frame(8'h00, 8'hFF, FAULT_TAIL2);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int           stop_at;
        int           pick;
        int           r;
        logic [7:0]   d;
        logic [7:0]   len;
        frame_fault_t fault;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    d = 8'($urandom);
                    if ($urandom_range(0, 3) == 0)
                        d = HDR_BYTE0;
                    send_byte(d);
                end
            end
            else if (pick == 1)
            begin
                send_byte(HDR_BYTE0);
                d = 8'($urandom);
                if ($urandom_range(0, 1) == 0)
                    d = HDR_BYTE0;
                send_byte(d);
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    len = 8'($urandom);
                else if (r < 3 && max_len < 8'hFF)
                    len = max_len + 8'd1;
                else if (r < 5 && max_len <= 8'd64)
                    len = max_len;
                else
                    len = 8'($urandom_range(0, 6));
                case ($urandom_range(0, 7))
                    0:       fault = FAULT_CRC;
                    1:       fault = FAULT_TAIL1;
                    2:       fault = FAULT_TAIL2;
                    default: fault = FAULT_NONE;
                endcase
                send_frame(len, 8'($urandom), fault);
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s expected %0h actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: out_kind %0d payload_byte %0h frame_status %0d",
                       out_kind, payload_byte, frame_status);
                errors++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("out_kind", {7'd0, oldest.kind}, {7'd0, out_kind});
                check_field("payload_byte", oldest.data, payload_byte);
                check_field("byte_index", oldest.index, byte_index);
                check_field("out_cmd", oldest.cmd, out_cmd);
                check_field("out_len", oldest.len, out_len);
                check_field("frame_status", {5'd0, oldest.status}, {5'd0, frame_status});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hunting();
        test_zero_length();
        test_length_limit();
        test_bad_tail();

        wait_idle();
        set_max_len(8'h00);
        test_random_traffic(60);

        wait_idle();
        set_max_len(8'hFF);
        test_random_traffic(150);

        wait_idle();
        set_max_len(8'($urandom_range(1, 254)));
        test_random_traffic(200);

        idle_on = 1'b0;
        wait_idle();
        set_max_len(8'd5);
        test_random_traffic(140);

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/crc8fr_pkg.sv
rtl/crc8_frame_receiver_unit.sv
rtl/crc8fr_checker.sv
bench/tb.sv
